@@ rtl/assert_macros.svh @@
// Assertion macros shared by the field finder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PBFF_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("field finder assertion failed");

// Expression must never be true at a clock edge outside reset.
`define PBFF_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("field finder forbidden condition seen");

`endif

@@ rtl/pbff_pkg.sv @@
// Types, constants and codes shared by the protobuf field finder.
package pbff_pkg;

   // Message and varint limits.
   localparam int MAX_MSG_BYTES    = 65536;
   localparam int POS_W            = $clog2(MAX_MSG_BYTES) + 1;
   localparam int VARINT_MAX_BYTES = 10;
   localparam int VB_W             = $clog2(VARINT_MAX_BYTES + 1);
   localparam int ACC_W            = 64;
   localparam int VARINT_DIGIT_W   = 7;

   // Field widths of the words on the ports.
   localparam int FIELD_NUM_W = 32;
   localparam int WIRE_W      = 3;
   localparam int OFFSET_W    = 16;
   localparam int LENGTH_W    = 32;
   localparam int CSR_DATA_W  = 32;

   // Wire type codes.
   localparam logic [WIRE_W-1:0] WIRE_VARINT  = 3'd0;
   localparam logic [WIRE_W-1:0] WIRE_FIXED64 = 3'd1;
   localparam logic [WIRE_W-1:0] WIRE_DELIM   = 3'd2;
   localparam logic [WIRE_W-1:0] WIRE_FIXED32 = 3'd5;

   localparam logic [LENGTH_W-1:0] FIXED64_LEN = 32'd8;
   localparam logic [LENGTH_W-1:0] FIXED32_LEN = 32'd4;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_FIELD_NUMBER = 1'b0,
      CSR_WIRE_KIND    = 1'b1
   } csr_index_type;

   // Scanner phases.
   typedef enum logic [2:0] {
      PH_TAG         = 3'd0,
      PH_VAL_VARINT  = 3'd1,
      PH_LEN         = 3'd2,
      PH_SKIP_VARINT = 3'd3,
      PH_SKIP_LEN    = 3'd4,
      PH_SKIP_BYTES  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [FIELD_NUM_W-1:0] field_number;
      logic [WIRE_W-1:0]      wire_kind;
   } cfg_type;

   typedef struct packed {
      logic                 found;
      logic [OFFSET_W-1:0]  payload_offset;
      logic [LENGTH_W-1:0]  payload_length;
   } result_type;

endpackage

@@ rtl/pbff_scan.sv @@
// Byte-wise wire-format scanner: tag and varint decode, skip logic, result.
`include "assert_macros.svh"

module pbff_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            msg_byte,
   input  logic                  msg_end,
   input  pbff_pkg::cfg_type     cfg,
   output logic                  res_valid,
   output pbff_pkg::result_type  res
);

   pbff_pkg::phase_type                 phase_ff, phase_in;
   logic [pbff_pkg::POS_W-1:0]          byte_position_ff, byte_position_in;
   logic [pbff_pkg::ACC_W-1:0]          varint_accum_ff, varint_accum_in;
   logic [pbff_pkg::VB_W-1:0]           varint_bytes_ff, varint_bytes_in;
   logic [pbff_pkg::LENGTH_W-1:0]       skip_remaining_ff, skip_remaining_in;
   logic [pbff_pkg::OFFSET_W-1:0]       payload_start_ff, payload_start_in;
   logic                                done_flag_ff, done_flag_in;

   logic [pbff_pkg::ACC_W-1:0]          acc_feed;
   logic [pbff_pkg::VB_W-1:0]           bytes_next;
   logic                                v_done, v_bad;
   logic                                pos_over;
   logic [31:0]                         pos_plus;
   logic [pbff_pkg::OFFSET_W-1:0]       off_next;
   logic [pbff_pkg::LENGTH_W-1:0]       acc_sat;
   logic [pbff_pkg::FIELD_NUM_W-1:0]    tag_field;
   logic [pbff_pkg::WIRE_W-1:0]         tag_wire;
   logic                                tag_match, wire_fixed, wire_known;
   logic [pbff_pkg::LENGTH_W-1:0]       fixed_len, skip_dec;

   // Place the seven payload bits of this byte into the slot its count selects.
   always_comb begin
      acc_feed = varint_accum_ff;
      for (int i = 0; i < pbff_pkg::VARINT_MAX_BYTES; i++) begin
         if (varint_bytes_ff == pbff_pkg::VB_W'(i)) begin
            acc_feed = varint_accum_ff |
                       (pbff_pkg::ACC_W'(msg_byte[6:0]) << (pbff_pkg::VARINT_DIGIT_W * i));
         end
      end
   end

   assign bytes_next = varint_bytes_ff + pbff_pkg::VB_W'(1);
   assign v_done     = !msg_byte[7];
   assign v_bad      = msg_byte[7] &&
                       (bytes_next >= pbff_pkg::VB_W'(pbff_pkg::VARINT_MAX_BYTES));

   assign pos_over = (byte_position_ff >= pbff_pkg::POS_W'(pbff_pkg::MAX_MSG_BYTES));
   assign pos_plus = 32'(byte_position_ff) + 32'd1;
   assign off_next = (pos_plus > 32'h0000_FFFF) ? '1 : pos_plus[pbff_pkg::OFFSET_W-1:0];

   assign acc_sat  = (|acc_feed[pbff_pkg::ACC_W-1:pbff_pkg::LENGTH_W]) ? '1 :
                     acc_feed[pbff_pkg::LENGTH_W-1:0];

   assign tag_field  = acc_feed[pbff_pkg::FIELD_NUM_W+2:3];
   assign tag_wire   = acc_feed[pbff_pkg::WIRE_W-1:0];
   assign tag_match  = (tag_field == cfg.field_number) && (tag_wire == cfg.wire_kind);
   assign wire_fixed = (tag_wire == pbff_pkg::WIRE_FIXED64) ||
                       (tag_wire == pbff_pkg::WIRE_FIXED32);
   assign wire_known = wire_fixed || (tag_wire == pbff_pkg::WIRE_VARINT) ||
                       (tag_wire == pbff_pkg::WIRE_DELIM);
   assign fixed_len  = (tag_wire == pbff_pkg::WIRE_FIXED64) ? pbff_pkg::FIXED64_LEN :
                       pbff_pkg::FIXED32_LEN;
   assign skip_dec   = (skip_remaining_ff == '0) ? '0 :
                       skip_remaining_ff - pbff_pkg::LENGTH_W'(1);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (msg_end) begin
            phase_in = pbff_pkg::PH_TAG;
         end else if (!done_flag_ff && !pos_over) begin
            unique case (phase_ff)
               pbff_pkg::PH_TAG: begin
                  if (v_done) begin
                     if (tag_match) begin
                        if (tag_wire == pbff_pkg::WIRE_VARINT) begin
                           phase_in = pbff_pkg::PH_VAL_VARINT;
                        end else if (tag_wire == pbff_pkg::WIRE_DELIM) begin
                           phase_in = pbff_pkg::PH_LEN;
                        end
                     end else if (tag_wire == pbff_pkg::WIRE_VARINT) begin
                        phase_in = pbff_pkg::PH_SKIP_VARINT;
                     end else if (tag_wire == pbff_pkg::WIRE_DELIM) begin
                        phase_in = pbff_pkg::PH_SKIP_LEN;
                     end else if (wire_fixed) begin
                        phase_in = pbff_pkg::PH_SKIP_BYTES;
                     end
                  end
               end
               pbff_pkg::PH_SKIP_VARINT: begin
                  if (v_done) begin
                     phase_in = pbff_pkg::PH_TAG;
                  end
               end
               pbff_pkg::PH_SKIP_LEN: begin
                  if (v_done) begin
                     phase_in = (acc_sat == '0) ? pbff_pkg::PH_TAG : pbff_pkg::PH_SKIP_BYTES;
                  end
               end
               pbff_pkg::PH_SKIP_BYTES: begin
                  if (skip_dec == '0) begin
                     phase_in = pbff_pkg::PH_TAG;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // Result of this byte: at most one per message.
   always_comb begin
      res_valid          = 1'b0;
      res.found          = 1'b0;
      res.payload_offset = '0;
      res.payload_length = '0;
      if (accept && !done_flag_ff) begin
         if (pos_over) begin
            res_valid = 1'b1;
         end else begin
            unique case (phase_ff)
               pbff_pkg::PH_TAG: begin
                  if (v_bad) begin
                     res_valid = 1'b1;
                  end else if (v_done) begin
                     if (tag_match && wire_fixed) begin
                        res_valid          = 1'b1;
                        res.found          = 1'b1;
                        res.payload_offset = off_next;
                        res.payload_length = fixed_len;
                     end else if (!wire_known) begin
                        res_valid = 1'b1;
                     end
                  end
               end
               pbff_pkg::PH_VAL_VARINT: begin
                  if (v_bad) begin
                     res_valid = 1'b1;
                  end else if (v_done) begin
                     res_valid          = 1'b1;
                     res.found          = 1'b1;
                     res.payload_offset = payload_start_ff;
                     res.payload_length = pbff_pkg::LENGTH_W'(bytes_next);
                  end
               end
               pbff_pkg::PH_LEN: begin
                  if (v_bad) begin
                     res_valid = 1'b1;
                  end else if (v_done) begin
                     res_valid          = 1'b1;
                     res.found          = 1'b1;
                     res.payload_offset = off_next;
                     res.payload_length = acc_sat;
                  end
               end
               pbff_pkg::PH_SKIP_VARINT,
               pbff_pkg::PH_SKIP_LEN: begin
                  res_valid = v_bad;
               end
               default: res_valid = 1'b0;
            endcase
         end
         // The message end closes the message with a result if it has none yet.
         if (!res_valid && msg_end) begin
            res_valid = 1'b1;
         end
      end
   end

   // Varint accumulator, skip counter, position and done flag.
   always_comb begin
      byte_position_in  = byte_position_ff;
      varint_accum_in   = varint_accum_ff;
      varint_bytes_in   = varint_bytes_ff;
      skip_remaining_in = skip_remaining_ff;
      payload_start_in  = payload_start_ff;
      done_flag_in      = done_flag_ff;
      if (accept) begin
         if (msg_end) begin
            byte_position_in  = '0;
            varint_accum_in   = '0;
            varint_bytes_in   = '0;
            skip_remaining_in = '0;
            payload_start_in  = '0;
            done_flag_in      = 1'b0;
         end else if (!done_flag_ff) begin
            done_flag_in = res_valid;
            if (!pos_over) begin
               byte_position_in = byte_position_ff + pbff_pkg::POS_W'(1);
               if (phase_ff == pbff_pkg::PH_SKIP_BYTES) begin
                  skip_remaining_in = skip_dec;
                  if (skip_dec == '0) begin
                     varint_accum_in = '0;
                     varint_bytes_in = '0;
                  end
               end else begin
                  varint_accum_in = acc_feed;
                  varint_bytes_in = bytes_next;
                  if (v_done) begin
                     if (phase_ff == pbff_pkg::PH_TAG) begin
                        varint_accum_in = '0;
                        varint_bytes_in = '0;
                        if (tag_match && tag_wire == pbff_pkg::WIRE_VARINT) begin
                           payload_start_in = off_next;
                        end
                        if (!tag_match && wire_fixed) begin
                           skip_remaining_in = fixed_len;
                        end
                     end else if (phase_ff == pbff_pkg::PH_SKIP_VARINT) begin
                        varint_accum_in = '0;
                        varint_bytes_in = '0;
                     end else if (phase_ff == pbff_pkg::PH_SKIP_LEN) begin
                        varint_accum_in   = '0;
                        varint_bytes_in   = '0;
                        skip_remaining_in = acc_sat;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= pbff_pkg::PH_TAG;
         byte_position_ff  <= '0;
         varint_accum_ff   <= '0;
         varint_bytes_ff   <= '0;
         skip_remaining_ff <= '0;
         payload_start_ff  <= '0;
         done_flag_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         byte_position_ff  <= byte_position_in;
         varint_accum_ff   <= varint_accum_in;
         varint_bytes_ff   <= varint_bytes_in;
         skip_remaining_ff <= skip_remaining_in;
         payload_start_ff  <= payload_start_in;
         done_flag_ff      <= done_flag_in;
      end
   end

   `PBFF_ASSERT(a_done_quiet, clock, reset, (accept && done_flag_ff) |-> !res_valid)
   `PBFF_ASSERT(a_varint_bound, clock, reset,
                !done_flag_ff |-> (varint_bytes_ff < pbff_pkg::VB_W'(pbff_pkg::VARINT_MAX_BYTES)))
   `PBFF_NEVER(a_skip_nonzero, clock, reset,
               !done_flag_ff && phase_ff == pbff_pkg::PH_SKIP_BYTES && skip_remaining_ff == '0)

endmodule

@@ rtl/pbff_rsp_buf.sv @@
// Result register with a skid stage between the scanner and the result channel.
`include "assert_macros.svh"

module pbff_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  pbff_pkg::result_type  in_res,
   output logic                  in_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output pbff_pkg::result_type  rsp_res
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   pbff_pkg::result_type  out_res_ff, out_res_in;
   pbff_pkg::result_type  skid_res_ff, skid_res_in;
   logic                  out_free;

   // The skid stage absorbs one word that arrives while the output stalls.
   assign in_ready = !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = skid_res_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_res_in   = in_res;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_res_in   = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_res    = out_res_ff;

   `PBFF_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff)
   `PBFF_NEVER(a_no_write_when_full, clock, reset, skid_valid_ff && in_valid)

endmodule

@@ rtl/protobuf_field_finder_core.sv @@
// Top level of the protobuf field finder: ports, configuration registers, wiring.
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------
//   req_    | in        | tdata: msg_byte; tlast: msg_end
//   rsp_    | out       | tdata: payload_offset, payload_length; tuser: found
//   csr_    | in        | index 0 target_field_number, 1 target_wire_kind
//
// The scanner updates its varint and skip state in the cycle a byte is accepted;
// its result word is registered in the output stage of the result buffer, or in
// the skid stage while rsp_ stalls. Every message gives exactly one result word.
// A stalled result channel is absorbed by a one-word skid stage; req_tready
// drops only while that stage is full. Reset is synchronous and active high;
// it clears the scanner and both configuration registers.
// Configuration writes are always accepted and act on the next tag compared.

module protobuf_field_finder_core (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] msg_byte
   input  logic         req_tlast,   // msg_end

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // [15:0] payload_offset, [47:16] payload_length
   output logic         rsp_tuser,   // found

   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data
);

   pbff_pkg::cfg_type     cfg_ff, cfg_in;
   pbff_pkg::result_type  scan_res, rsp_res;
   logic                  scan_valid;
   logic                  buf_ready;
   logic                  req_accept;

   // Configuration registers; the port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (pbff_pkg::csr_index_type'(csr_index))
            pbff_pkg::CSR_FIELD_NUMBER: cfg_in.field_number = csr_data;
            pbff_pkg::CSR_WIRE_KIND:    cfg_in.wire_kind = csr_data[pbff_pkg::WIRE_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A byte is taken whenever the result path can hold whatever it causes.
   assign req_tready = buf_ready;
   assign req_accept = req_tvalid && req_tready;

   pbff_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .msg_byte  (req_tdata),
      .msg_end   (req_tlast),
      .cfg       (cfg_ff),
      .res_valid (scan_valid),
      .res       (scan_res)
   );

   pbff_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (scan_valid),
      .in_res     (scan_res),
      .in_ready   (buf_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {rsp_res.payload_length, rsp_res.payload_offset};
   assign rsp_tuser = rsp_res.found;

endmodule
